[design/ec_scalar_multiply_defines.svh]
// ----------------------------------------------------------------------------
// ec_scalar_multiply_defines.svh
// Assertion macros for the scalar multiply RTL.
// ----------------------------------------------------------------------------
`ifndef EC_SCALAR_MULTIPLY_DEFINES_SVH
`define EC_SCALAR_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ECSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ECSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ecsm_pkg.sv]
// ----------------------------------------------------------------------------
// ecsm_pkg
// Types and constants for the elliptic curve scalar multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecsm_pkg;

  localparam int FIELD_BITS_DEF  = 16;
  localparam int SCALAR_BITS_DEF = 32;
  localparam int CFG_BITS        = 16;

  localparam logic [CFG_BITS-1:0] CURVE_A_RST = 16'd0;
  localparam logic [CFG_BITS-1:0] MODULUS_RST = 16'd5;

  // register index on the APB port
  localparam logic REG_CURVE_A = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  typedef enum logic {
    OP_MUL,   // (a * b) mod p
    OP_DIV    // a / b, a % b
  } ecsm_op_t;

  typedef struct packed {
    logic     start;
    ecsm_op_t op;
  } ecsm_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED_A, S_RED_X, S_RED_Y, S_CHECK, S_FIND, S_LOOP,
    S_DBL, S_D_SQ, S_D_3, S_D_NUM, S_D_DEN,
    S_ADD,
    S_INV_START, S_INV_TEST, S_INV_DIV, S_INV_MUL, S_INV_UPD, S_INV_END,
    S_LAM, S_C_SQ, S_C_X1, S_C_X2, S_C_D, S_C_M, S_C_Y,
    S_NEXT, S_FIN
  } ecsm_state_t;

endpackage

[design/ecsm_arith.sv]
// ----------------------------------------------------------------------------
// ecsm_arith
// Bit-serial modular multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecsm_arith #(
  parameter int W = ecsm_pkg::CFG_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ecsm_pkg::ecsm_ctl_t ctl,
  input  logic [W-1:0]      opa,
  input  logic [W-1:0]      opb,
  input  logic [W-1:0]      mod_p,
  output logic              done,
  output logic [W-1:0]      res_q,
  output logic [W-1:0]      res_r
);

  localparam int CW = $clog2(W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [W-1:0]        sh_r, sh_nxt;
  logic [W-1:0]        b_r, b_nxt;
  logic [W-1:0]        p_r, p_nxt;
  ecsm_pkg::ecsm_op_t  op_r, op_nxt;

  logic [W:0] dbl, sum, rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
    op_r  <= op_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    p_nxt    = p_r;
    op_nxt   = op_r;
    // multiply step: acc = 2*acc + bit*b, kept below p
    dbl = {acc_r, 1'b0};
    if (dbl >= {1'b0, p_r}) dbl = dbl - {1'b0, p_r};
    sum = dbl + (sh_r[W-1] ? {1'b0, b_r} : '0);
    if (sum >= {1'b0, p_r}) sum = sum - {1'b0, p_r};
    // divide step: shift in next dividend bit, trial subtract
    rem = {acc_r, sh_r[W-1]};
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W-1);
      acc_nxt  = '0;
      sh_nxt   = opa;
      b_nxt    = opb;
      p_nxt    = mod_p;
      op_nxt   = ctl.op;
    end else if (busy_r) begin
      unique case (op_r)
        ecsm_pkg::OP_MUL: begin
          acc_nxt = sum[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
        ecsm_pkg::OP_DIV: begin
          if (rem >= {1'b0, b_r}) begin
            acc_nxt = W'(rem - {1'b0, b_r});
            sh_nxt  = {sh_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = rem[W-1:0];
            sh_nxt  = {sh_r[W-2:0], 1'b0};
          end
        end
        default: acc_nxt = acc_r;
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign res_q = sh_r;
  assign res_r = acc_r;

endmodule

[design/ec_scalar_multiply.sv]
// ----------------------------------------------------------------------------
// ec_scalar_multiply
// Double-and-add scalar multiply on y^2 = x^3 + ax + b over a small field.
// ----------------------------------------------------------------------------
// Operation: each field multiply or divide holds the shared serial unit from
//   its launch through one bit step per operand bit to its result (W =
//   max(FIELD_BITS,16)). A field inverse runs up to ~1.5*W Euclid rounds of divide + multiply.
//   Per scalar bit: doubling = inverse + 6 multiplies, add = inverse + 3.
// Throughput: one transaction at a time; in_ready is high only when idle.
// Reset: synchronous active-low; curve_a -> 0, field_modulus -> 5, no result.
`timescale 1ns / 1ps
`include "ec_scalar_multiply_defines.svh"

module ec_scalar_multiply #(
  parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
  parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input transactions
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FIELD_BITS-1:0]  in_base_x,
  input  logic [FIELD_BITS-1:0]  in_base_y,
  input  logic [SCALAR_BITS-1:0] in_scalar,
  // result transactions
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_BITS-1:0]  out_result_x,
  output logic [FIELD_BITS-1:0]  out_result_y,
  output logic                   out_at_infinity,
  output logic                   out_scalar_error,
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // arithmetic width: wide enough for both the field and the config registers
  localparam int AW = (FIELD_BITS > ecsm_pkg::CFG_BITS) ? FIELD_BITS : ecsm_pkg::CFG_BITS;
  localparam int IW = $clog2(SCALAR_BITS);

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic [ecsm_pkg::CFG_BITS-1:0] curve_a_r, modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r <= ecsm_pkg::CURVE_A_RST;
      modulus_r <= ecsm_pkg::MODULUS_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ecsm_pkg::REG_MODULUS) modulus_r <= pwdata[15:0];
      else                                   curve_a_r <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ecsm_pkg::REG_MODULUS) ? 32'(modulus_r) : 32'(curve_a_r);

  // --------------------------------------------------------------------------
  // field add/sub helpers, operands already below m
  // --------------------------------------------------------------------------
  function automatic logic [AW-1:0] f_sub(input logic [AW-1:0] u, input logic [AW-1:0] v,
                                          input logic [AW-1:0] m);
    logic [AW:0] d;
    d = {1'b0, u} - {1'b0, v};
    if (u < v) d = d + {1'b0, m};
    return d[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] f_add(input logic [AW-1:0] u, input logic [AW-1:0] v,
                                          input logic [AW-1:0] m);
    logic [AW:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // sequencer state
  // --------------------------------------------------------------------------
  ecsm_pkg::ecsm_state_t state_r, state_nxt;
  logic                   pend_r, pend_nxt;     // waiting on the serial unit
  logic [AW-1:0]          p_r, p_nxt;
  logic [AW-1:0]          a_r, a_nxt;
  logic [AW-1:0]          bx_r, bx_nxt, by_r, by_nxt;
  logic [SCALAR_BITS-1:0] k_r, k_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   bit_r, bit_nxt;       // current scalar bit
  logic                   phase_r, phase_nxt;   // 1 while in the add step
  logic [AW-1:0]          ax_r, ax_nxt, ay_r, ay_nxt;
  logic                   ainf_r, ainf_nxt;
  logic                   err_r, err_nxt;
  logic [AW-1:0]          num_r, num_nxt;       // numerator, later the slope
  logic [AW-1:0]          den_r, den_nxt;       // denominator, inverse, x diff
  logic [AW-1:0]          t1_r, t1_nxt;
  logic [AW-1:0]          qx_r, qx_nxt;
  logic [AW-1:0]          r0_r, r0_nxt, r1_r, r1_nxt;
  logic [AW-1:0]          u0_r, u0_nxt, u1_r, u1_nxt;
  logic [AW-1:0]          q_r, q_nxt, rem_r, rem_nxt;

  logic                   ovalid_r, ovalid_nxt;
  logic [FIELD_BITS-1:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic                   oinf_r, oinf_nxt, oerr_r, oerr_nxt;

  // shared serial unit
  ecsm_pkg::ecsm_ctl_t ar_ctl;
  logic [AW-1:0]       ar_a, ar_b;
  logic                ar_done;
  logic [AW-1:0]       ar_q, ar_r;
  logic [AW-1:0]       three_m;

  ecsm_arith #(.W(AW)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ar_ctl),
    .opa   (ar_a),
    .opb   (ar_b),
    .mod_p (p_r),
    .done  (ar_done),
    .res_q (ar_q),
    .res_r (ar_r)
  );

  // 3 mod p; p >= 3 during the run
  assign three_m = (p_r == AW'(3)) ? '0 : AW'(3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ecsm_pkg::S_IDLE;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
    p_r <= p_nxt;   a_r <= a_nxt;   bx_r <= bx_nxt; by_r <= by_nxt;
    k_r <= k_nxt;   idx_r <= idx_nxt; bit_r <= bit_nxt; phase_r <= phase_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; ainf_r <= ainf_nxt; err_r <= err_nxt;
    num_r <= num_nxt; den_r <= den_nxt; t1_r <= t1_nxt; qx_r <= qx_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; u0_r <= u0_nxt; u1_r <= u1_nxt;
    q_r <= q_nxt;   rem_r <= rem_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; oinf_r <= oinf_nxt; oerr_r <= oerr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    p_nxt = p_r;   a_nxt = a_r;   bx_nxt = bx_r; by_nxt = by_r;
    k_nxt = k_r;   idx_nxt = idx_r; bit_nxt = bit_r; phase_nxt = phase_r;
    ax_nxt = ax_r; ay_nxt = ay_r; ainf_nxt = ainf_r; err_nxt = err_r;
    num_nxt = num_r; den_nxt = den_r; t1_nxt = t1_r; qx_nxt = qx_r;
    r0_nxt = r0_r; r1_nxt = r1_r; u0_nxt = u0_r; u1_nxt = u1_r;
    q_nxt = q_r;   rem_nxt = rem_r;
    ox_nxt = ox_r; oy_nxt = oy_r; oinf_nxt = oinf_r; oerr_nxt = oerr_r;
    ovalid_nxt = ovalid_r && !out_ready;

    ar_ctl.start = 1'b0;
    ar_ctl.op    = ecsm_pkg::OP_MUL;
    ar_a         = '0;
    ar_b         = '0;

    unique case (state_r)
      ecsm_pkg::S_IDLE: begin
        if (in_valid) begin
          p_nxt   = AW'(modulus_r);
          bx_nxt  = AW'(in_base_x);
          by_nxt  = AW'(in_base_y);
          k_nxt   = in_scalar;
          idx_nxt = IW'(SCALAR_BITS - 1);
          err_nxt = (in_scalar == '0);
          ainf_nxt = 1'b1;
          if (in_scalar == '0 || modulus_r < 16'd3) state_nxt = ecsm_pkg::S_FIN;
          else                                      state_nxt = ecsm_pkg::S_RED_A;
        end
      end
      // operand reduction modulo p
      ecsm_pkg::S_RED_A: begin
        ar_ctl.op = ecsm_pkg::OP_DIV; ar_a = AW'(curve_a_r); ar_b = p_r;
        if (pend_r && ar_done) begin a_nxt = ar_r; state_nxt = ecsm_pkg::S_RED_X; end
      end
      ecsm_pkg::S_RED_X: begin
        ar_ctl.op = ecsm_pkg::OP_DIV; ar_a = bx_r; ar_b = p_r;
        if (pend_r && ar_done) begin bx_nxt = ar_r; state_nxt = ecsm_pkg::S_RED_Y; end
      end
      ecsm_pkg::S_RED_Y: begin
        ar_ctl.op = ecsm_pkg::OP_DIV; ar_a = by_r; ar_b = p_r;
        if (pend_r && ar_done) begin by_nxt = ar_r; state_nxt = ecsm_pkg::S_CHECK; end
      end
      ecsm_pkg::S_CHECK: begin
        // (0,0) after reduction is the point at infinity
        if (bx_r == '0 && by_r == '0) begin
          state_nxt = ecsm_pkg::S_FIN;
        end else begin
          ax_nxt = bx_r; ay_nxt = by_r; ainf_nxt = 1'b0;
          state_nxt = ecsm_pkg::S_FIND;
        end
      end
      // skip leading zeros of the scalar, one bit a cycle
      ecsm_pkg::S_FIND: begin
        if (k_r[SCALAR_BITS-1]) begin
          state_nxt = ecsm_pkg::S_LOOP;
        end else begin
          k_nxt   = k_r << 1;
          idx_nxt = idx_r - 1'b1;
        end
      end
      ecsm_pkg::S_LOOP: begin
        if (idx_r == '0) begin
          state_nxt = ecsm_pkg::S_FIN;
        end else begin
          bit_nxt   = k_r[SCALAR_BITS-2];
          k_nxt     = k_r << 1;
          idx_nxt   = idx_r - 1'b1;
          phase_nxt = 1'b0;
          state_nxt = ecsm_pkg::S_DBL;
        end
      end
      // doubling: lam = (3x^2 + a) / 2y
      ecsm_pkg::S_DBL: begin
        if (ainf_r || ay_r == '0) begin
          ainf_nxt  = 1'b1;
          state_nxt = ecsm_pkg::S_NEXT;
        end else begin
          state_nxt = ecsm_pkg::S_D_SQ;
        end
      end
      ecsm_pkg::S_D_SQ: begin
        ar_a = ax_r; ar_b = ax_r;
        if (pend_r && ar_done) begin t1_nxt = ar_r; state_nxt = ecsm_pkg::S_D_3; end
      end
      ecsm_pkg::S_D_3: begin
        ar_a = t1_r; ar_b = three_m;
        if (pend_r && ar_done) begin t1_nxt = ar_r; state_nxt = ecsm_pkg::S_D_NUM; end
      end
      ecsm_pkg::S_D_NUM: begin
        num_nxt   = f_add(t1_r, a_r, p_r);
        state_nxt = ecsm_pkg::S_D_DEN;
      end
      ecsm_pkg::S_D_DEN: begin
        ar_a = AW'(2); ar_b = ay_r;
        if (pend_r && ar_done) begin
          den_nxt   = ar_r;
          qx_nxt    = ax_r;
          state_nxt = ecsm_pkg::S_INV_START;
        end
      end
      // addition of the base point
      ecsm_pkg::S_ADD: begin
        if (ainf_r) begin
          ax_nxt = bx_r; ay_nxt = by_r; ainf_nxt = 1'b0;
          state_nxt = ecsm_pkg::S_NEXT;
        end else if (ax_r == bx_r) begin
          if (ay_r == by_r) begin
            state_nxt = ecsm_pkg::S_DBL;
          end else begin
            ainf_nxt  = 1'b1;
            state_nxt = ecsm_pkg::S_NEXT;
          end
        end else begin
          num_nxt   = f_sub(by_r, ay_r, p_r);
          den_nxt   = f_sub(bx_r, ax_r, p_r);
          qx_nxt    = bx_r;
          state_nxt = ecsm_pkg::S_INV_START;
        end
      end
      // field inverse by extended Euclid, coefficients kept mod p
      ecsm_pkg::S_INV_START: begin
        r0_nxt = p_r; r1_nxt = den_r; u0_nxt = '0; u1_nxt = AW'(1);
        state_nxt = ecsm_pkg::S_INV_TEST;
      end
      ecsm_pkg::S_INV_TEST: begin
        state_nxt = (r1_r == '0) ? ecsm_pkg::S_INV_END : ecsm_pkg::S_INV_DIV;
      end
      ecsm_pkg::S_INV_DIV: begin
        ar_ctl.op = ecsm_pkg::OP_DIV; ar_a = r0_r; ar_b = r1_r;
        if (pend_r && ar_done) begin
          // quotient never exceeds p
          q_nxt     = (ar_q >= p_r) ? ar_q - p_r : ar_q;
          rem_nxt   = ar_r;
          state_nxt = ecsm_pkg::S_INV_MUL;
        end
      end
      ecsm_pkg::S_INV_MUL: begin
        ar_a = q_r; ar_b = u1_r;
        if (pend_r && ar_done) begin q_nxt = ar_r; state_nxt = ecsm_pkg::S_INV_UPD; end
      end
      ecsm_pkg::S_INV_UPD: begin
        r0_nxt = r1_r; r1_nxt = rem_r;
        u0_nxt = u1_r; u1_nxt = f_sub(u0_r, q_r, p_r);
        state_nxt = ecsm_pkg::S_INV_TEST;
      end
      ecsm_pkg::S_INV_END: begin
        // no inverse when gcd is not one
        den_nxt   = (r0_r == AW'(1)) ? u0_r : '0;
        state_nxt = ecsm_pkg::S_LAM;
      end
      ecsm_pkg::S_LAM: begin
        ar_a = num_r; ar_b = den_r;
        if (pend_r && ar_done) begin num_nxt = ar_r; state_nxt = ecsm_pkg::S_C_SQ; end
      end
      // chord: rx = lam^2 - x - qx, ry = lam*(x - rx) - y
      ecsm_pkg::S_C_SQ: begin
        ar_a = num_r; ar_b = num_r;
        if (pend_r && ar_done) begin t1_nxt = ar_r; state_nxt = ecsm_pkg::S_C_X1; end
      end
      ecsm_pkg::S_C_X1: begin
        t1_nxt = f_sub(t1_r, ax_r, p_r); state_nxt = ecsm_pkg::S_C_X2;
      end
      ecsm_pkg::S_C_X2: begin
        t1_nxt = f_sub(t1_r, qx_r, p_r); state_nxt = ecsm_pkg::S_C_D;
      end
      ecsm_pkg::S_C_D: begin
        den_nxt = f_sub(ax_r, t1_r, p_r); state_nxt = ecsm_pkg::S_C_M;
      end
      ecsm_pkg::S_C_M: begin
        ar_a = num_r; ar_b = den_r;
        if (pend_r && ar_done) begin q_nxt = ar_r; state_nxt = ecsm_pkg::S_C_Y; end
      end
      ecsm_pkg::S_C_Y: begin
        ay_nxt = f_sub(q_r, ay_r, p_r);
        ax_nxt = t1_r;
        ainf_nxt  = 1'b0;
        state_nxt = ecsm_pkg::S_NEXT;
      end
      ecsm_pkg::S_NEXT: begin
        if (!phase_r && bit_r) begin
          phase_nxt = 1'b1;
          state_nxt = ecsm_pkg::S_ADD;
        end else begin
          state_nxt = ecsm_pkg::S_LOOP;
        end
      end
      // hold until the output register is free
      ecsm_pkg::S_FIN: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ox_nxt     = ainf_r ? '0 : ax_r[FIELD_BITS-1:0];
          oy_nxt     = ainf_r ? '0 : ay_r[FIELD_BITS-1:0];
          oinf_nxt   = ainf_r;
          oerr_nxt   = err_r;
          state_nxt  = ecsm_pkg::S_IDLE;
        end
      end
      default: state_nxt = ecsm_pkg::S_IDLE;
    endcase

    // launch the serial unit once in every state that uses it
    if (state_r == ecsm_pkg::S_RED_A || state_r == ecsm_pkg::S_RED_X ||
        state_r == ecsm_pkg::S_RED_Y || state_r == ecsm_pkg::S_D_SQ ||
        state_r == ecsm_pkg::S_D_3   || state_r == ecsm_pkg::S_D_DEN ||
        state_r == ecsm_pkg::S_INV_DIV || state_r == ecsm_pkg::S_INV_MUL ||
        state_r == ecsm_pkg::S_LAM   || state_r == ecsm_pkg::S_C_SQ ||
        state_r == ecsm_pkg::S_C_M) begin
      ar_ctl.start = !pend_r;
      if (!pend_r)      pend_nxt = 1'b1;
      else if (ar_done) pend_nxt = 1'b0;
    end
  end

  assign in_ready         = (state_r == ecsm_pkg::S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_result_x     = ox_r;
  assign out_result_y     = oy_r;
  assign out_at_infinity  = oinf_r;
  assign out_scalar_error = oerr_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic out_xy_zero;
  assign out_xy_zero = (out_result_x == '0) && (out_result_y == '0);

  `ECSM_ASSERT_NOW(a_err_inf, out_valid && out_scalar_error, out_at_infinity, "err not inf")
  `ECSM_ASSERT_NOW(a_inf_zero, out_valid && out_at_infinity, out_xy_zero, "inf not zero")
  `ECSM_ASSERT_NOW(a_done_pend, ar_done, pend_r, "serial unit done with no request")
  `ECSM_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "accept did not start")

endmodule
